// File: hdl/hrbg_pkg.sv
`default_nettype none

package hrbg_pkg;

    // Field widths fixed by the interface.
    localparam int COUNT_W = 6;    // ring_count register
    localparam int WIDTH_W = 32;   // ring_width register
    localparam int OFFS_W  = 40;   // offset_l / offset_m, 32 fraction bits
    localparam int BEAM_W  = 14;   // beam_number
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_WIDTH = 1'b1;

    // sqrt(3)/2 with 32 fraction bits.
    localparam logic [WIDTH_W-1:0] HALF_SQRT3_Q32 = 32'hDDB3_D743;

    // One result beat.
    typedef struct packed {
        logic [OFFS_W-1:0] offset_l;
        logic [OFFS_W-1:0] offset_m;
        logic [BEAM_W-1:0] beam_number;
        logic              final_beam;
    } t_beam;

endpackage

`default_nettype wire

// File: hdl/hex_ring_beam_grid_generator_core.sv
`default_nettype none

// Hexagonal ring beam grid generator.
// Each beat on the input channel (i_in_valid / o_in_ready) is one tick carrying
// i_restart. A tick yields at most one beat on the output channel
// (o_out_valid / i_out_ready): the (l, m) pointing offset of the next beam,
// its position in the sequence and a flag on the last beam of the grid. The
// centre comes first, then each ring clockwise from its top.
// Ring count and ring width are written through the configuration channel
// (i_cfg_valid / o_cfg_ready, always ready), index 0 and 1 respectively.
// The result of a tick sits in the output register on the cycle after the tick
// is taken. One tick is taken per cycle while the receiver keeps up, set by
// the single registered pass through the walk logic and the output register.
// A stalled receiver holds the output register; a new tick is still taken in
// the cycle in which the waiting beat is collected. Ticks that give no beat
// (zero rings, or the grid finished without a restart) are still taken as ticks.
// Reset zeroes all registers but the beam data one and rewinds the walk to the centre.
module hex_ring_beam_grid_generator_core
    import hrbg_pkg::*;
#(
    parameter int MAX_RINGS = 63
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Tick channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_restart,
    // Beam channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic signed [OFFS_W-1:0]  o_offset_l,
    output logic signed [OFFS_W-1:0]  o_offset_m,
    output logic        [BEAM_W-1:0]  o_beam_number,
    output logic                      o_final_beam,
    // Configuration channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WIDTH_W-1:0]   i_cfg_data
);

    logic [COUNT_W-1:0] r_ring_count;
    logic [WIDTH_W-1:0] r_ring_width;
    logic               r_out_valid;
    t_beam              r_beam;

    logic               w_in_accept;
    logic               w_has_result;
    logic               w_centre_beat;
    logic [WIDTH_W-1:0] w_column_step;
    t_beam              w_beam;

    // Configuration writes are taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_count <= '0;
            r_ring_width <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RING_COUNT: r_ring_count <= i_cfg_data[COUNT_W-1:0];
                CFG_RING_WIDTH: r_ring_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A tick is taken whenever the output register is free or being emptied.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_accept = i_in_valid && o_in_ready;

    hrbg_walk #(
        .MAX_RINGS (MAX_RINGS)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_in_accept),
        .i_restart     (i_restart),
        .i_ring_count  (r_ring_count),
        .i_ring_width  (r_ring_width),
        .i_column_step (w_column_step),
        .o_has_result  (w_has_result),
        .o_centre_beat (w_centre_beat),
        .o_beam        (w_beam)
    );

    // The horizontal step is captured with the centre beam of each pass.
    hrbg_col_step u_col_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_latch       (w_in_accept && w_centre_beat),
        .i_ring_width  (r_ring_width),
        .o_column_step (w_column_step)
    );

    // Output register: loaded by every accepted tick, cleared once collected.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= w_has_result;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && w_has_result) begin
            r_beam <= w_beam;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_offset_l    = r_beam.offset_l;
    assign o_offset_m    = r_beam.offset_m;
    assign o_beam_number = r_beam.beam_number;
    assign o_final_beam  = r_beam.final_beam;

    // The centre beam is always beam zero at the origin.
    a_centre_at_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && w_centre_beat) |=>
            (o_out_valid && o_offset_l == '0 && o_offset_m == '0 && o_beam_number == '0))
        else $error("centre beam not at the origin");

    // With no rings configured a tick gives nothing.
    a_zero_rings_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && r_ring_count == '0) |=> !o_out_valid)
        else $error("beam produced with zero rings");

    // A finished grid stays silent until a restart.
    a_silent_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && w_has_result && w_beam.final_beam) ##1
            (w_in_accept && !i_restart) |-> !w_has_result)
        else $error("beam produced after the final beam without a restart");

    // A restart tick that gives a beam always gives the centre beam.
    a_restart_gives_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_restart && w_has_result) |-> w_centre_beat)
        else $error("restart did not rewind to the centre");

endmodule

`default_nettype wire

// File: hdl/hrbg_col_step.sv
`default_nettype none

// Holds the horizontal step of the grid, round(W * sqrt(3)/2), captured from
// the live ring width whenever the centre beam is sent.
module hrbg_col_step
    import hrbg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_latch,
    input  wire logic [WIDTH_W-1:0] i_ring_width,
    output logic      [WIDTH_W-1:0] o_column_step
);

    logic [2*WIDTH_W-1:0] w_product;
    logic [2*WIDTH_W-1:0] w_rounded;
    logic [WIDTH_W-1:0]   r_column_step;

    // The product stays below 0.87 * 2^64, so adding one half cannot overflow.
    assign w_product = (2*WIDTH_W)'(i_ring_width) * (2*WIDTH_W)'(HALF_SQRT3_Q32);
    assign w_rounded = w_product + ((2*WIDTH_W)'(1) << (WIDTH_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_step <= '0;
        end else if (i_latch) begin
            r_column_step <= w_rounded[2*WIDTH_W-1:WIDTH_W];
        end
    end

    assign o_column_step = r_column_step;

endmodule

`default_nettype wire

// File: hdl/hrbg_walk.sv
`default_nettype none

// Walk state of the hexagonal grid: ring, side and step counters together with
// the two offset accumulators. The result for an accepted beat is formed
// combinationally from the current state; the state advances on acceptance.
module hrbg_walk
    import hrbg_pkg::*;
#(
    parameter int MAX_RINGS = 63
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic               i_restart,
    input  wire logic [COUNT_W-1:0] i_ring_count,
    input  wire logic [WIDTH_W-1:0] i_ring_width,
    input  wire logic [WIDTH_W-1:0] i_column_step,
    output logic                    o_has_result,
    output logic                    o_centre_beat,
    output t_beam                   o_beam
);

    localparam int RW = $clog2(MAX_RINGS + 1);
    localparam int LW = (RW > COUNT_W) ? RW : COUNT_W;
    localparam logic [RW-1:0] MAX_R = RW'(MAX_RINGS);

    // Sides in walking order, clockwise from the top of the ring.
    typedef enum logic [2:0] {
        SIDE_DOWN_RIGHT = 3'd0,
        SIDE_DOWN       = 3'd1,
        SIDE_DOWN_LEFT  = 3'd2,
        SIDE_UP_LEFT    = 3'd3,
        SIDE_UP         = 3'd4,
        SIDE_UP_RIGHT   = 3'd5
    } t_side;

    logic [RW-1:0]     r_ring,  n_ring,  s_ring;
    t_side             r_side,  n_side,  s_side;
    logic [RW-1:0]     r_step,  n_step,  s_step;
    logic [OFFS_W-1:0] r_acc_l, n_acc_l, s_acc_l;
    logic [OFFS_W-1:0] r_acc_m, n_acc_m, s_acc_m;   // twice m, in half units
    logic [OFFS_W-1:0] r_top,   n_top,   s_top;     // twice m at the ring start
    logic [BEAM_W-1:0] r_beam,  n_beam,  s_beam;
    logic              r_done,  n_done,  s_done;

    logic [LW-1:0]     w_count_ext;
    logic [LW-1:0]     w_max_ext;
    logic [RW-1:0]     w_limit;
    logic [OFFS_W-1:0] w_w;
    logic [OFFS_W-1:0] w_w2;
    logic [OFFS_W-1:0] w_c;
    logic [OFFS_W:0]   w_m_plus;
    logic              w_side_end;
    logic              w_last;
    logic [OFFS_W-1:0] w_l_moved;
    logic [OFFS_W-1:0] w_m_moved;
    logic [OFFS_W-1:0] w_top_next;

    assign w_count_ext = LW'(i_ring_count);
    assign w_max_ext   = LW'(MAX_RINGS);
    assign w_limit     = RW'((w_count_ext < w_max_ext) ? w_count_ext : w_max_ext);

    assign w_w  = OFFS_W'(i_ring_width);
    assign w_w2 = OFFS_W'({i_ring_width, 1'b0});
    assign w_c  = OFFS_W'(i_column_step);

    // A restart rewinds to the centre before anything else is looked at.
    always_comb begin
        if (i_restart) begin
            s_ring  = '0;
            s_side  = SIDE_DOWN_RIGHT;
            s_step  = '0;
            s_acc_l = '0;
            s_acc_m = '0;
            s_top   = '0;
            s_beam  = '0;
            s_done  = 1'b0;
        end else begin
            s_ring  = r_ring;
            s_side  = r_side;
            s_step  = r_step;
            s_acc_l = r_acc_l;
            s_acc_m = r_acc_m;
            s_top   = r_top;
            s_beam  = r_beam;
            s_done  = r_done;
        end
    end

    assign o_has_result  = !s_done && (w_limit != '0);
    assign o_centre_beat = o_has_result && (s_ring == '0);

    // m is half the accumulator, rounded half up: floor((2m + 1) / 2).
    assign w_m_plus = {s_acc_m[OFFS_W-1], s_acc_m} + (OFFS_W+1)'(1);

    assign w_side_end = ({1'b0, s_step} + (RW+1)'(1)) >= {1'b0, s_ring};
    assign w_last     = (s_ring >= w_limit) && (s_side == SIDE_UP_RIGHT) && w_side_end;
    assign w_top_next = s_top + w_w2;

    always_comb begin
        unique case (s_side)
            SIDE_DOWN_RIGHT: begin
                w_l_moved = s_acc_l + w_c;
                w_m_moved = s_acc_m - w_w;
            end
            SIDE_DOWN: begin
                w_l_moved = s_acc_l;
                w_m_moved = s_acc_m - w_w2;
            end
            SIDE_DOWN_LEFT: begin
                w_l_moved = s_acc_l - w_c;
                w_m_moved = s_acc_m - w_w;
            end
            SIDE_UP_LEFT: begin
                w_l_moved = s_acc_l - w_c;
                w_m_moved = s_acc_m + w_w;
            end
            SIDE_UP: begin
                w_l_moved = s_acc_l;
                w_m_moved = s_acc_m + w_w2;
            end
            default: begin
                w_l_moved = s_acc_l + w_c;
                w_m_moved = s_acc_m + w_w;
            end
        endcase
    end

    always_comb begin
        n_ring  = s_ring;
        n_side  = s_side;
        n_step  = s_step;
        n_acc_l = s_acc_l;
        n_acc_m = s_acc_m;
        n_top   = s_top;
        n_beam  = s_beam;
        n_done  = s_done;

        o_beam.beam_number = s_beam;
        o_beam.offset_l    = '0;
        o_beam.offset_m    = '0;
        o_beam.final_beam  = 1'b0;

        if (o_has_result) begin
            n_beam = s_beam + BEAM_W'(1);
            if (s_ring == '0) begin
                // Centre beam; the first ring starts straight above it.
                n_ring  = RW'(1);
                n_side  = SIDE_DOWN_RIGHT;
                n_step  = '0;
                n_top   = w_w2;
                n_acc_l = '0;
                n_acc_m = w_w2;
            end else begin
                o_beam.offset_l   = s_acc_l;
                o_beam.offset_m   = w_m_plus[OFFS_W:1];
                o_beam.final_beam = w_last;
                n_acc_l = w_l_moved;
                n_acc_m = w_m_moved;
                n_step  = s_step + RW'(1);
                if (w_side_end) begin
                    n_step = '0;
                    if (s_side == SIDE_UP_RIGHT) begin
                        // Ring closed: move out to the top of the next one.
                        n_side  = SIDE_DOWN_RIGHT;
                        n_ring  = (s_ring < MAX_R) ? s_ring + RW'(1) : s_ring;
                        n_top   = w_top_next;
                        n_acc_l = '0;
                        n_acc_m = w_top_next;
                    end else begin
                        n_side = t_side'(s_side + 3'd1);
                    end
                end
                n_done = w_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring  <= '0;
            r_side  <= SIDE_DOWN_RIGHT;
            r_step  <= '0;
            r_acc_l <= '0;
            r_acc_m <= '0;
            r_top   <= '0;
            r_beam  <= '0;
            r_done  <= 1'b0;
        end else if (i_accept) begin
            r_ring  <= n_ring;
            r_side  <= n_side;
            r_step  <= n_step;
            r_acc_l <= n_acc_l;
            r_acc_m <= n_acc_m;
            r_top   <= n_top;
            r_beam  <= n_beam;
            r_done  <= n_done;
        end
    end

endmodule

`default_nettype wire
